[rtl/lscw_pkg.sv]
// Package for the leaf span carrier window block.
// Holds field widths, register indexes, register reset values and shared types.
// No dependencies.
package lscw_pkg;

  // Field widths
  localparam int unsigned POS_W      = 16;
  localparam int unsigned TRAVEL_W   = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_RANGE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_ALLOWANCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_LOWER_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_CARRIER_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_TRAVEL_LIMIT   = 3'd4;

  // Configuration register reset values
  localparam logic [POS_W-1:0]    RST_LEAF_RANGE          = 16'd25025;
  localparam logic [POS_W-1:0]    RST_RANGE_ALLOWANCE     = 16'd162;
  localparam logic [POS_W-1:0]    RST_CARRIER_LOWER_LIMIT = 16'd2600;
  localparam logic [POS_W-1:0]    RST_LEAF_CARRIER_GAP    = 16'd3250;
  localparam logic [TRAVEL_W-1:0] RST_LEAF_TRAVEL_LIMIT   = 17'd28275;

  // Configuration register set
  typedef struct packed {
    logic [POS_W-1:0]    leaf_range;
    logic [POS_W-1:0]    range_allowance;
    logic [POS_W-1:0]    carrier_lower_limit;
    logic [POS_W-1:0]    leaf_carrier_gap;
    logic [TRAVEL_W-1:0] leaf_travel_limit;
  } cfg_t;

  // Closed group record handed from the tracker to the window stage
  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] max;
    logic [POS_W-1:0] min;
  } grp_t;

endpackage

[rtl/lscw_tracker.sv]
// Running maximum and minimum tracker for the leaf span carrier window block.
// Closes a group on its last leaf and holds the group record for the window stage.
// Depends on lscw_pkg.
module lscw_tracker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lscw_pkg::POS_W-1:0] in_leaf_position,
  input  logic                      in_last_leaf,
  output lscw_pkg::grp_t            grp,
  input  logic                      grp_take
);

  logic                       group_start_r, group_start_nxt;
  logic [lscw_pkg::POS_W-1:0] running_max_r, running_max_nxt;
  logic [lscw_pkg::POS_W-1:0] running_min_r, running_min_nxt;
  logic                       grp_vld_r, grp_vld_nxt;
  logic [lscw_pkg::POS_W-1:0] grp_max_r;
  logic [lscw_pkg::POS_W-1:0] grp_min_r;
  logic                       in_acc;

  // Accept while the group record is free or leaving this cycle
  assign in_ready = !grp_vld_r || grp_take;
  assign in_acc   = in_valid && in_ready;

  // Fold the new position into the running extremes
  always_comb begin
    if (group_start_r) begin
      running_max_nxt = in_leaf_position;
      running_min_nxt = in_leaf_position;
    end else begin
      running_max_nxt = (in_leaf_position > running_max_r) ? in_leaf_position : running_max_r;
      running_min_nxt = (in_leaf_position < running_min_r) ? in_leaf_position : running_min_r;
    end
  end

  // Track group boundaries and the record valid flag
  always_comb begin
    group_start_nxt = group_start_r;
    grp_vld_nxt     = grp_vld_r;
    if (grp_take) begin
      grp_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      group_start_nxt = in_last_leaf;
      if (in_last_leaf) begin
        grp_vld_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_start_r <= 1'b1;
      grp_vld_r     <= 1'b0;
    end else begin
      group_start_r <= group_start_nxt;
      grp_vld_r     <= grp_vld_nxt;
    end
  end

  // Extremes and closed group record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_max_r <= '0;
      running_min_r <= '0;
    end else if (in_acc) begin
      running_max_r <= running_max_nxt;
      running_min_r <= running_min_nxt;
      if (in_last_leaf) begin
        grp_max_r <= running_max_nxt;
        grp_min_r <= running_min_nxt;
      end
    end
  end

  assign grp.vld = grp_vld_r;
  assign grp.max = grp_max_r;
  assign grp.min = grp_min_r;

  // A held group record is ordered
  a_grp_order: assert property (@(posedge clk) disable iff (!rst_n)
    grp_vld_r |-> (grp_min_r <= grp_max_r))
    else $error("group record minimum above maximum");

  // Running extremes stay ordered inside a group
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    !group_start_r |-> (running_min_r <= running_max_r))
    else $error("running minimum above maximum");

  // A closing transaction always leaves a record behind
  a_close_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_leaf) |=> (grp_vld_r && group_start_r))
    else $error("closing transaction lost its group record");

endmodule

[rtl/lscw_window.sv]
// Carrier window stage for the leaf span carrier window block.
// Checks the span, derives and clamps the window bounds and holds the result register.
// Depends on lscw_pkg.
module lscw_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lscw_pkg::cfg_t              cfg,
  input  lscw_pkg::grp_t              grp,
  output logic                        grp_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lscw_pkg::POS_W-1:0]  out_carrier_low,
  output logic [lscw_pkg::POS_W-1:0]  out_carrier_high,
  output logic [lscw_pkg::POS_W-1:0]  out_leaf_maximum,
  output logic                        out_span_error
);

  localparam int unsigned DW = lscw_pkg::POS_W + 2;

  logic                       out_vld_r, out_vld_nxt;
  logic [lscw_pkg::POS_W-1:0] low_r, high_r, max_r;
  logic                       err_r;

  logic [lscw_pkg::POS_W-1:0] span;
  logic [lscw_pkg::POS_W:0]   span_lim;
  logic                       err;
  logic signed [DW-1:0]       lo_diff, hi_diff, lim_ext;
  logic [lscw_pkg::POS_W-1:0] lo_raw, hi_raw, lo_fin, hi_fin;

  // Load the result register when it is empty or being drained
  assign grp_take = grp.vld && (!out_vld_r || out_ready);

  // Span check at 17 bits
  assign span     = grp.max - grp.min;
  assign span_lim = {1'b0, cfg.leaf_range} + {1'b0, cfg.range_allowance};
  assign err      = {1'b0, span} > span_lim;

  // Signed bound differences, raised to the carrier lower limit
  assign lo_diff = $signed({2'b00, grp.max}) - $signed({1'b0, cfg.leaf_travel_limit});
  assign hi_diff = $signed({2'b00, grp.min}) - $signed({2'b00, cfg.leaf_carrier_gap});
  assign lim_ext = $signed({2'b00, cfg.carrier_lower_limit});

  assign lo_raw = (lo_diff >= lim_ext) ? lo_diff[lscw_pkg::POS_W-1:0] : cfg.carrier_lower_limit;
  assign hi_raw = (hi_diff >= lim_ext) ? hi_diff[lscw_pkg::POS_W-1:0] : cfg.carrier_lower_limit;

  // Pull low down to high when the window inverts; zero window on error
  always_comb begin
    if (err) begin
      lo_fin = '0;
      hi_fin = '0;
    end else begin
      hi_fin = hi_raw;
      lo_fin = (hi_raw < lo_raw) ? hi_raw : lo_raw;
    end
  end

  // Result valid flag
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (grp_take) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (grp_take) begin
      low_r  <= lo_fin;
      high_r <= hi_fin;
      max_r  <= grp.max;
      err_r  <= err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_carrier_low  = low_r;
  assign out_carrier_high = high_r;
  assign out_leaf_maximum = max_r;
  assign out_span_error   = err_r;

  // An error result carries a zero window
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && err_r) |-> (low_r == '0 && high_r == '0))
    else $error("span error result with nonzero window");

  // A good window is never inverted
  a_win_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !err_r) |-> (low_r <= high_r))
    else $error("carrier window inverted");

  // A good window never falls below the carrier lower limit
  a_win_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_take && !err) |-> (lo_fin >= cfg.carrier_lower_limit))
    else $error("carrier window below lower limit");

endmodule

[rtl/leaf_span_carrier_window.sv]
// Top level of the leaf span carrier window block: configuration registers,
// tracker and window stage. Depends on lscw_pkg, lscw_tracker and lscw_window.
//
// Leaf positions stream in one transaction per cycle; a group ends at the
// transaction with in_last_leaf set, and that group's single result passes
// through the tracker's group record and then the output register. Sustained
// rate is one leaf per cycle while the output is not stalled: the tracker
// compare and the window subtract-and-clamp each take one register stage.
// in_ready drops only while a closed group waits behind a stalled output.
// Configuration writes are taken every cycle (cfg_ready is tied high) and must
// only happen while the block is idle; writes to unknown indexes are dropped.
module leaf_span_carrier_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lscw_pkg::POS_W-1:0]      in_leaf_position,
  input  logic                            in_last_leaf,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lscw_pkg::POS_W-1:0]      out_carrier_low,
  output logic [lscw_pkg::POS_W-1:0]      out_carrier_high,
  output logic [lscw_pkg::POS_W-1:0]      out_leaf_maximum,
  output logic                            out_span_error,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lscw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lscw_pkg::CFG_DATA_W-1:0] cfg_data
);

  lscw_pkg::cfg_t cfg_r;
  lscw_pkg::grp_t grp;
  logic           grp_take;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leaf_range          <= lscw_pkg::RST_LEAF_RANGE;
      cfg_r.range_allowance     <= lscw_pkg::RST_RANGE_ALLOWANCE;
      cfg_r.carrier_lower_limit <= lscw_pkg::RST_CARRIER_LOWER_LIMIT;
      cfg_r.leaf_carrier_gap    <= lscw_pkg::RST_LEAF_CARRIER_GAP;
      cfg_r.leaf_travel_limit   <= lscw_pkg::RST_LEAF_TRAVEL_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lscw_pkg::REG_LEAF_RANGE:
          cfg_r.leaf_range <= cfg_data[lscw_pkg::POS_W-1:0];
        lscw_pkg::REG_RANGE_ALLOWANCE:
          cfg_r.range_allowance <= cfg_data[lscw_pkg::POS_W-1:0];
        lscw_pkg::REG_CARRIER_LOWER_LIMIT:
          cfg_r.carrier_lower_limit <= cfg_data[lscw_pkg::POS_W-1:0];
        lscw_pkg::REG_LEAF_CARRIER_GAP:
          cfg_r.leaf_carrier_gap <= cfg_data[lscw_pkg::POS_W-1:0];
        lscw_pkg::REG_LEAF_TRAVEL_LIMIT:
          cfg_r.leaf_travel_limit <= cfg_data[lscw_pkg::TRAVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Running extremes and group closing
  lscw_tracker u_tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_leaf_position (in_leaf_position),
    .in_last_leaf     (in_last_leaf),
    .grp              (grp),
    .grp_take         (grp_take)
  );

  // Span check, window bounds and result register
  lscw_window u_window (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .grp              (grp),
    .grp_take         (grp_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_carrier_low  (out_carrier_low),
    .out_carrier_high (out_carrier_high),
    .out_leaf_maximum (out_leaf_maximum),
    .out_span_error   (out_span_error)
  );

endmodule
